// ===== rtl/bcc_pkg.sv =====
`default_nettype none

package bcc_pkg;

	localparam int unsigned TIME_WIDTH_DEF = 32;
	localparam int unsigned STAMP_WIDTH    = 32;
	localparam int unsigned CFG_WIDTH      = 16;
	localparam int unsigned CFG_IDX_WIDTH  = 2;

	localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_WIDTH-1:0] DOUBLE_RST   = 16'd400;
	localparam logic [CFG_WIDTH-1:0] LONG_RST     = 16'd1000;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		CFG_DEBOUNCE = 2'd0,
		CFG_DOUBLE   = 2'd1,
		CFG_LONG     = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		EV_NONE         = 3'd0,
		EV_SINGLE       = 3'd1,
		EV_DOUBLE       = 3'd2,
		EV_LONG         = 3'd3,
		EV_LONG_RELEASE = 3'd4
	} event_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] debounce_time;
		logic [CFG_WIDTH-1:0] double_click_window;
		logic [CFG_WIDTH-1:0] long_hold_time;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/bcc_core.sv =====
`default_nettype none

module bcc_core #(
	parameter int unsigned TIME_WIDTH = bcc_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  fire,
	input  wire logic                  raw_level,
	input  wire logic [TIME_WIDTH-1:0] now,
	input  wire bcc_pkg::cfg_t         cfg,
	output bcc_pkg::event_t            event_code
);
	import bcc_pkg::*;

	logic                  stable_q, prev_raw_q, await_q, second_q, long_q;
	logic [TIME_WIDTH-1:0] deb_stamp_q, click_stamp_q, press_stamp_q;

	logic                  stable_n, prev_raw_n, await_n, second_n, long_n;
	logic [TIME_WIDTH-1:0] deb_stamp_n, click_stamp_n, press_stamp_n;
	logic [TIME_WIDTH-1:0] deb_time, dcw_time, lp_time;
	logic [TIME_WIDTH-1:0] e_deb, e_held, e_press, e_click;
	logic                  accept, done;
	event_t                ev;

	assign deb_time = TIME_WIDTH'(cfg.debounce_time);
	assign dcw_time = TIME_WIDTH'(cfg.double_click_window);
	assign lp_time  = TIME_WIDTH'(cfg.long_hold_time);

	assign deb_stamp_n = (raw_level != prev_raw_q) ? now : deb_stamp_q;
	assign e_deb       = now - deb_stamp_n;
	assign e_held      = now - press_stamp_q;
	assign accept      = (e_deb >= deb_time) && (raw_level != stable_q);

	always_comb begin
		stable_n      = stable_q;
		prev_raw_n    = prev_raw_q;
		await_n       = await_q;
		second_n      = second_q;
		long_n        = long_q;
		click_stamp_n = click_stamp_q;
		press_stamp_n = press_stamp_q;
		ev            = EV_NONE;
		done          = 1'b0;
		if (accept) begin
			stable_n = raw_level;
			if (!raw_level) begin
				press_stamp_n = now;
				long_n        = 1'b0;
				second_n      = await_q;
			end else if (long_q) begin
				long_n  = 1'b0;
				await_n = 1'b0;
				ev      = EV_LONG_RELEASE;
				done    = 1'b1;
			end else if (second_q) begin
				second_n = 1'b0;
				await_n  = 1'b0;
				ev       = EV_DOUBLE;
				done     = 1'b1;
			end else if (e_held < lp_time) begin
				await_n       = 1'b1;
				click_stamp_n = now;
			end
		end
		e_press = now - press_stamp_n;
		e_click = now - click_stamp_n;
		if (!done) begin
			if (!stable_n && !long_n && !second_n && !await_n && (e_press >= lp_time)) begin
				long_n = 1'b1;
				ev     = EV_LONG;
			end else if (await_n && !second_n && (e_click > dcw_time)) begin
				await_n = 1'b0;
				ev      = EV_SINGLE;
			end else begin
				prev_raw_n = raw_level;
			end
		end
	end

	assign event_code = ev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q      <= 1'b1;
			prev_raw_q    <= 1'b1;
			await_q       <= 1'b0;
			second_q      <= 1'b0;
			long_q        <= 1'b0;
			deb_stamp_q   <= '0;
			click_stamp_q <= '0;
			press_stamp_q <= '0;
		end else if (fire) begin
			stable_q      <= stable_n;
			prev_raw_q    <= prev_raw_n;
			await_q       <= await_n;
			second_q      <= second_n;
			long_q        <= long_n;
			deb_stamp_q   <= deb_stamp_n;
			click_stamp_q <= click_stamp_n;
			press_stamp_q <= press_stamp_n;
		end
	end

	a_second_needs_await: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> await_q)
		else $error("second press active without pending click");

	a_long_excludes_second: assert property (@(posedge clk) disable iff (!arst_n)
		long_q |-> !second_q)
		else $error("long press flagged during second press");

	a_long_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ev == EV_LONG) |=> long_q)
		else $error("long press reported without flag");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (ev == EV_LONG_RELEASE || ev == EV_DOUBLE)) |=> (!await_q && !second_q))
		else $error("release left click state armed");

endmodule

`default_nettype wire

// ===== rtl/button_click_classifier.sv =====
// Button click classifier.
// Input channel (in_valid/in_ready): one poll of an active-low button per item,
// raw_level (0 pressed) and now_ms, a free-running millisecond timestamp whose
// low TIME_WIDTH bits are used; time differences wrap at that width.
// Output channel (out_valid/out_ready): one event_code item per poll, in order:
// none, single click, double click, long press, release after long press.
// Configuration: write cfg_data to register cfg_index (0 debounce time,
// 1 double-click window, 2 long-press time) while cfg_we is high; other
// indexes are ignored. Write only while no poll is in flight.
// The event of a poll passes the input register, the classify logic and the
// result register before it is offered.
// Throughput: one poll per cycle while results are taken. A stalled receiver
// holds the result register; one further poll waits in the input register,
// after which in_ready drops until the result is taken.
// Reset returns the registers to 50/400/1000 ms, the button to released and
// clears all click state and the valid flags of both pipeline registers.
`default_nettype none

module button_click_classifier #(
	parameter int unsigned TIME_WIDTH = bcc_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              raw_level,
	input  wire logic [bcc_pkg::STAMP_WIDTH-1:0]   now_ms,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [2:0]                             event_code,
	input  wire logic                              cfg_we,
	input  wire logic [bcc_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  wire logic [bcc_pkg::CFG_WIDTH-1:0]     cfg_data
);
	import bcc_pkg::*;

	cfg_t                   cfg_q;
	logic                   valid_s1, raw_s1;
	logic [STAMP_WIDTH-1:0] now_s1;
	logic                   out_valid_q;
	event_t                 event_q, ev;
	logic                   move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time       <= DEBOUNCE_RST;
			cfg_q.double_click_window <= DOUBLE_RST;
			cfg_q.long_hold_time      <= LONG_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE: cfg_q.debounce_time       <= cfg_data;
				CFG_DOUBLE:   cfg_q.double_click_window <= cfg_data;
				CFG_LONG:     cfg_q.long_hold_time      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign move     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			raw_s1 <= raw_level;
			now_s1 <= now_ms;
		end
	end

	bcc_core #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (move),
		.raw_level (raw_s1),
		.now       (TIME_WIDTH'(now_s1)),
		.cfg       (cfg_q),
		.event_code(ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			event_q <= ev;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_code = event_q;

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(event_q)))
		else $error("result dropped while stalled");

	a_in_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |-> !in_ready)
		else $error("poll accepted with both registers full");

	a_move_fills: assert property (@(posedge clk) disable iff (!arst_n)
		move |=> out_valid_q)
		else $error("classified poll lost");

endmodule

`default_nettype wire

// ===== dv/tb_button_click_classifier.sv =====
`default_nettype none

module tb_button_click_classifier;
	timeunit 1ns;
	timeprecision 1ps;

	import bcc_pkg::*;

	localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE = 2'd3;
	localparam int PHASES      = 8;
	localparam int PHASE_POLLS = 225;
	localparam int DIR_ROWS    = 28;

	typedef enum logic { ROW_POLL, ROW_CFG } row_kind_t;

	typedef struct packed {
		row_kind_t                kind;
		logic [CFG_IDX_WIDTH-1:0] reg_idx;
		logic [CFG_WIDTH-1:0]     value;
		logic                     level;
		logic [STAMP_WIDTH-1:0]   stamp;
		logic                     typed;
		event_t                   want;
	} dir_row_t;

	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b1, 32'd0,          1'b1, EV_NONE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b0, 32'd10,         1'b0, EV_NONE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b0, 32'd60,         1'b0, EV_NONE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b1, 32'd200,        1'b0, EV_NONE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b1, 32'd250,        1'b0, EV_NONE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b1, 32'd651,        1'b1, EV_SINGLE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b0, 32'd1000,       1'b0, EV_NONE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b0, 32'd1050,       1'b0, EV_NONE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b1, 32'd1100,       1'b0, EV_NONE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b1, 32'd1150,       1'b0, EV_NONE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b0, 32'd1200,       1'b0, EV_NONE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b0, 32'd1250,       1'b0, EV_NONE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b1, 32'd1300,       1'b0, EV_NONE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b1, 32'd1350,       1'b1, EV_DOUBLE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b0, 32'd2000,       1'b0, EV_NONE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b0, 32'd2050,       1'b0, EV_NONE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b0, 32'd3050,       1'b1, EV_LONG},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b1, 32'd3600,       1'b0, EV_NONE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b1, 32'd3650,       1'b1, EV_LONG_RELEASE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b0, 32'hFFFF_FFC0,  1'b0, EV_NONE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b0, 32'hFFFF_FFF2,  1'b0, EV_NONE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b1, 32'h0000_0010,  1'b0, EV_NONE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b1, 32'h0000_0042,  1'b0, EV_NONE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b1, 32'h0000_01D3,  1'b1, EV_SINGLE},
		'{ROW_CFG,  CFG_SPARE,    16'hFFFF, 1'b1, 32'd0,       1'b0, EV_NONE},
		'{ROW_CFG,  CFG_DEBOUNCE, 16'd0, 1'b1, 32'd0,          1'b0, EV_NONE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b0, 32'd5000,       1'b0, EV_NONE},
		'{ROW_POLL, CFG_DEBOUNCE, 16'd0, 1'b1, 32'd6500,       1'b0, EV_NONE}
	};

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic                     raw_level;
	logic [STAMP_WIDTH-1:0]   now_ms;
	logic                     out_valid;
	logic                     out_ready;
	logic [2:0]               event_code;
	logic                     cfg_we;
	logic [CFG_IDX_WIDTH-1:0] cfg_index;
	logic [CFG_WIDTH-1:0]     cfg_data;

	logic [CFG_WIDTH-1:0]   deb_ms;
	logic [CFG_WIDTH-1:0]   win_ms;
	logic [CFG_WIDTH-1:0]   long_ms;
	logic                   m_stable;
	logic                   m_prev_raw;
	logic [STAMP_WIDTH-1:0] m_db_stamp;
	logic [STAMP_WIDTH-1:0] m_click_stamp;
	logic [STAMP_WIDTH-1:0] m_press_stamp;
	logic                   m_awaiting;
	logic                   m_second;
	logic                   m_long_done;

	event_t                 expected_events [$];
	logic [STAMP_WIDTH-1:0] clock_ms;
	int                     send_idle_pct;
	int                     stall_pct;
	int                     polls_sent;
	int                     mismatches;
	int                     events_seen [5];

	button_click_classifier u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.raw_level  (raw_level),
		.now_ms     (now_ms),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_code (event_code),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t ns mismatch: %s", $time, what);
	endtask

	task automatic reset_model();
		deb_ms        = DEBOUNCE_RST;
		win_ms        = DOUBLE_RST;
		long_ms       = LONG_RST;
		m_stable      = 1'b1;
		m_prev_raw    = 1'b1;
		m_db_stamp    = '0;
		m_click_stamp = '0;
		m_press_stamp = '0;
		m_awaiting    = 1'b0;
		m_second      = 1'b0;
		m_long_done   = 1'b0;
	endtask

	function automatic event_t classify_poll(input logic level, input logic [STAMP_WIDTH-1:0] now);
		logic [STAMP_WIDTH-1:0] held;
		if (level != m_prev_raw)
			m_db_stamp = now;
		if ((now - m_db_stamp) >= deb_ms && level != m_stable) begin
			m_stable = level;
			if (!m_stable) begin
				m_press_stamp = now;
				m_long_done   = 1'b0;
				m_second      = m_awaiting;
			end else begin
				held = now - m_press_stamp;
				if (m_long_done) begin
					m_long_done = 1'b0;
					m_awaiting  = 1'b0;
					return EV_LONG_RELEASE;
				end
				if (m_second) begin
					m_second   = 1'b0;
					m_awaiting = 1'b0;
					return EV_DOUBLE;
				end
				if (held < long_ms) begin
					m_awaiting    = 1'b1;
					m_click_stamp = now;
				end
			end
		end
		if (!m_stable && !m_long_done && !m_second && !m_awaiting &&
		    (now - m_press_stamp) >= long_ms) begin
			m_long_done = 1'b1;
			return EV_LONG;
		end
		if (m_awaiting && !m_second && (now - m_click_stamp) > win_ms) begin
			m_awaiting = 1'b0;
			return EV_SINGLE;
		end
		m_prev_raw = level;
		return EV_NONE;
	endfunction

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin : check_events
		event_t want;
		if (arst_n && out_valid && out_ready) begin
			if (event_code <= 3'd4)
				events_seen[event_code]++;
			if (expected_events.size() == 0) begin
				report_mismatch($sformatf("event %0d with no poll waiting", event_code));
			end else begin
				want = expected_events.pop_front();
				if (event_code !== want)
					report_mismatch($sformatf("event_code %0d, predicted %0d (%s)",
						event_code, want, want.name()));
			end
		end
	end

	task automatic send_poll(input logic level, input logic [STAMP_WIDTH-1:0] stamp,
	                         input logic typed, input event_t want);
		int     gap;
		event_t model_ev;
		gap = 0;
		@(negedge clk);
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		raw_level <= level;
		now_ms    <= stamp;
		do @(posedge clk); while (!in_ready);
		model_ev = classify_poll(level, stamp);
		expected_events.push_back(typed ? want : model_ev);
		polls_sent++;
	endtask

	task automatic drain_events();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			CFG_DEBOUNCE: deb_ms  = value;
			CFG_DOUBLE:   win_ms  = value;
			CFG_LONG:     long_ms = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [CFG_WIDTH-1:0] deb, input logic [CFG_WIDTH-1:0] win,
	                          input logic [CFG_WIDTH-1:0] lng);
		write_reg(CFG_DEBOUNCE, deb);
		write_reg(CFG_DOUBLE, win);
		write_reg(CFG_LONG, lng);
	endtask

	task automatic set_idle(input int mode);
		case (mode)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 77; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 77; end
			default: begin send_idle_pct = 29; stall_pct = 29; end
		endcase
	endtask

	function automatic logic [STAMP_WIDTH-1:0] pick_span();
		logic [STAMP_WIDTH-1:0] d;
		logic [STAMP_WIDTH-1:0] w;
		logic [STAMP_WIDTH-1:0] l;
		d = deb_ms;
		w = win_ms;
		l = long_ms;
		case ($urandom_range(10))
			0, 1:    return $urandom_range(0, d);
			2, 3:    return d + $urandom_range(0, w / 2);
			4, 5:    return d + $urandom_range(0, w + d + 1);
			6, 7:    return l + $urandom_range(0, l / 2 + d + 1);
			8, 9:    return $urandom_range(0, 2 * l + 2 * d + w + 2);
			default: return $urandom_range(0, 32'h7FFF_FFFF);
		endcase
	endfunction

	// alternate press and release holds with bounce in front, plus some noise
	task automatic run_gestures(input int polls);
		int                     sent;
		int                     bounce;
		logic                   level;
		logic [STAMP_WIDTH-1:0] hold;
		logic [STAMP_WIDTH-1:0] begin_ms;
		sent  = 0;
		level = 1'b1;
		while (sent < polls) begin
			if ($urandom_range(9) == 0) begin
				if ($urandom_range(3) == 0)
					clock_ms = $urandom;
				send_poll(1'($urandom_range(1)), clock_ms, 1'b0, EV_NONE);
				sent++;
				clock_ms += $urandom_range(0, 60);
			end else begin
				level  = ~level;
				hold   = pick_span();
				bounce = $urandom_range(3);
				while (bounce > 0 && sent < polls) begin
					send_poll(1'($urandom_range(1)), clock_ms, 1'b0, EV_NONE);
					sent++;
					bounce--;
					clock_ms += $urandom_range(0, deb_ms);
				end
				begin_ms = clock_ms;
				while (sent < polls) begin
					send_poll(level, clock_ms, 1'b0, EV_NONE);
					sent++;
					clock_ms += $urandom_range(1, hold / 5 + 1);
					if ((clock_ms - begin_ms) >= hold)
						break;
				end
			end
		end
	endtask

	initial begin
		int ph;
		in_valid      = 1'b0;
		raw_level     = 1'b1;
		now_ms        = '0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_DEBOUNCE;
		cfg_data      = '0;
		arst_n        = 1'b0;
		polls_sent    = 0;
		mismatches    = 0;
		clock_ms      = '0;
		foreach (events_seen[k])
			events_seen[k] = 0;
		set_idle(0);
		reset_model();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_idle(3);
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIRECTED[i].kind == ROW_CFG) begin
				drain_events();
				write_reg(DIRECTED[i].reg_idx, DIRECTED[i].value);
			end else begin
				send_poll(DIRECTED[i].level, DIRECTED[i].stamp, DIRECTED[i].typed,
					DIRECTED[i].want);
			end
		end

		for (ph = 0; ph < PHASES; ph++) begin
			drain_events();
			case (ph)
				0: set_config(DEBOUNCE_RST, DOUBLE_RST, LONG_RST);
				1: set_config(16'd0, 16'd0, 16'd0);
				2: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: set_config(16'd5, 16'd20, 16'd40);
				4: set_config(CFG_WIDTH'($urandom_range(0, 300)),
					CFG_WIDTH'($urandom_range(0, 2000)),
					CFG_WIDTH'($urandom_range(0, 4000)));
				5: begin
					write_reg(CFG_SPARE, CFG_WIDTH'($urandom_range(0, 16'hFFFF)));
					set_config(CFG_WIDTH'($urandom_range(0, 16'hFFFF)),
						CFG_WIDTH'($urandom_range(0, 16'hFFFF)),
						CFG_WIDTH'($urandom_range(0, 16'hFFFF)));
				end
				6: set_config(16'd0, 16'hFFFF, 16'd1);
				default: set_config(CFG_WIDTH'($urandom_range(1, 100)),
					CFG_WIDTH'($urandom_range(50, 800)),
					CFG_WIDTH'($urandom_range(100, 2000)));
			endcase
			set_idle(ph % 4);
			clock_ms = $urandom;
			run_gestures(PHASE_POLLS);
		end
		drain_events();

		$display("covered %0d polls over %0d register settings, with and without idling",
			polls_sent, PHASES + 2);
		$display("events seen: %0d single, %0d double, %0d long, %0d release after long",
			events_seen[EV_SINGLE], events_seen[EV_DOUBLE], events_seen[EV_LONG],
			events_seen[EV_LONG_RELEASE]);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
